### rtl/core/tek_pkg.sv
// Shared constants for the track extrapolation core: field widths, reset values,
// configuration register indexes and result codes. No dependencies.
package tek_pkg;

	typedef logic [1:0] code_t;

	localparam int POS_WIDTH_DEF = 32;
	localparam int MOM_WIDTH_DEF = 28;
	localparam int KICK_WIDTH = 27;

	localparam int MAGNET_Z_RESET = 3151920;
	localparam int KICK_RESET = 270000;

	// A slope quotient is held at this power of two.
	localparam int QUOT_LIMIT_LOG2 = 62;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNET_Z = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KICK = 1'd1;

	localparam code_t KT_NONE = 2'd0;
	localparam code_t KT_FWD = 2'd1;
	localparam code_t KT_BWD = 2'd2;

	localparam code_t ST_OK = 2'd0;
	localparam code_t ST_PZ_BAD = 2'd1;
	localparam code_t ST_KICK_BAD = 2'd2;

endpackage

### rtl/core/tek_sat_add.sv
// Adds a signed, limited slope quotient to a position and saturates the sum.
// Depends on tek_pkg.
module tek_sat_add #(
	parameter int POS_W = 32,
	parameter int Q_W = 60
) (
	input  logic signed [POS_W-1:0] base,
	input  logic        [Q_W-1:0]   quo,
	input  logic                    neg,
	output logic signed [POS_W-1:0] sum
);

	localparam int QX = (Q_W > 63) ? Q_W : 63;
	localparam int SW = QX + 2;
	localparam logic [QX-1:0] QLIM = QX'(1) << tek_pkg::QUOT_LIMIT_LOG2;

	logic        [QX-1:0] qx;
	logic        [QX-1:0] qc;
	logic signed [SW-1:0] be;
	logic signed [SW-1:0] qs;
	logic signed [SW-1:0] tot;

	always_comb begin
		qx = QX'(quo);
		qc = (qx > QLIM) ? QLIM : qx;
		be = SW'(base);
		qs = $signed({2'b00, qc});
		if (neg) begin
			qs = -qs;
		end
		tot = be + qs;
		// The sum fits when all bits from the position's sign bit up agree.
		if (tot[SW-1:POS_W-1] == '0 || tot[SW-1:POS_W-1] == '1) begin
			sum = tot[POS_W-1:0];
		end else if (tot[SW-1]) begin
			sum = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			sum = {1'b0, {(POS_W-1){1'b1}}};
		end
	end

endmodule

### rtl/core/tek_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a side word
// that travels alongside. No package dependencies.
module tek_sqrt_pipe #(
	parameter int RAD_W = 56,
	parameter int SB_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [RAD_W-1:0]    rad,
	input  logic [SB_W-1:0]     side_in,
	output logic                out_valid,
	output logic [RAD_W/2-1:0]  root,
	output logic [SB_W-1:0]     side_out
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int T_W = REM_W + 2;

	logic [ROOT_W-1:0] vld_q;
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SB_W-1:0]   side_s [ROOT_W];
	logic [RAD_W-1:0]  nrad   [ROOT_W];
	logic [REM_W-1:0]  nrem   [ROOT_W];
	logic [ROOT_W-1:0] nroot  [ROOT_W];

	always_comb begin
		logic [RAD_W-1:0]  prad;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		logic [T_W-1:0]    t;
		logic [T_W-1:0]    trial;
		logic              ge;
		for (int i = 0; i < ROOT_W; i++) begin
			if (i == 0) begin
				prad = rad;
				prem = '0;
				proot = '0;
			end else begin
				prad = rad_s[i-1];
				prem = rem_s[i-1];
				proot = root_s[i-1];
			end
			t = {prem, prad[RAD_W-1:RAD_W-2]};
			trial = T_W'({proot, 2'b01});
			ge = (t >= trial);
			nrad[i] = prad << 2;
			nrem[i] = ge ? REM_W'(t - trial) : REM_W'(t);
			nroot[i] = {proot[ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ROOT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rad_s[i] <= nrad[i];
				rem_s[i] <= nrem[i];
				root_s[i] <= nroot[i];
				side_s[i] <= (i == 0) ? side_in : side_s[i-1];
			end
		end
	end

	assign out_valid = vld_q[ROOT_W-1];
	assign root = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

### rtl/core/tek_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators over
// one shared divisor, with a side word alongside. No package dependencies.
module tek_div_pipe #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 28,
	parameter int SB_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  side_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo_a,
	output logic [NUM_W-1:0] quo_b,
	output logic [SB_W-1:0]  side_out
);

	// The numerator shifts out at the top while quotient bits shift in below.
	logic [NUM_W-1:0] vld_q;
	logic [NUM_W-1:0] na_s   [NUM_W];
	logic [NUM_W-1:0] nb_s   [NUM_W];
	logic [DEN_W-1:0] ra_s   [NUM_W];
	logic [DEN_W-1:0] rb_s   [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];
	logic [SB_W-1:0]  side_s [NUM_W];
	logic [NUM_W-1:0] nna    [NUM_W];
	logic [NUM_W-1:0] nnb    [NUM_W];
	logic [DEN_W-1:0] nra    [NUM_W];
	logic [DEN_W-1:0] nrb    [NUM_W];

	always_comb begin
		logic [NUM_W-1:0] pa;
		logic [NUM_W-1:0] pb;
		logic [DEN_W-1:0] pra;
		logic [DEN_W-1:0] prb;
		logic [DEN_W:0]   pd;
		logic [DEN_W:0]   ta;
		logic [DEN_W:0]   tb;
		logic             ga;
		logic             gb;
		for (int i = 0; i < NUM_W; i++) begin
			if (i == 0) begin
				pa = num_a;
				pb = num_b;
				pra = '0;
				prb = '0;
				pd = {1'b0, den};
			end else begin
				pa = na_s[i-1];
				pb = nb_s[i-1];
				pra = ra_s[i-1];
				prb = rb_s[i-1];
				pd = {1'b0, den_s[i-1]};
			end
			ta = {pra, pa[NUM_W-1]};
			tb = {prb, pb[NUM_W-1]};
			ga = (ta >= pd);
			gb = (tb >= pd);
			nna[i] = {pa[NUM_W-2:0], ga};
			nnb[i] = {pb[NUM_W-2:0], gb};
			nra[i] = ga ? DEN_W'(ta - pd) : DEN_W'(ta);
			nrb[i] = gb ? DEN_W'(tb - pd) : DEN_W'(tb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_W; i++) begin
				na_s[i] <= nna[i];
				nb_s[i] <= nnb[i];
				ra_s[i] <= nra[i];
				rb_s[i] <= nrb[i];
				den_s[i] <= (i == 0) ? den : den_s[i-1];
				side_s[i] <= (i == 0) ? side_in : side_s[i-1];
			end
		end
	end

	assign out_valid = vld_q[NUM_W-1];
	assign quo_a = na_s[NUM_W-1];
	assign quo_b = nb_s[NUM_W-1];
	assign side_out = side_s[NUM_W-1];

endmodule

### rtl/core/track_extrapolate_with_magnet_kick_core.sv
// Throughput: one word per cycle while the output register is not stalled; the
// bit-per-stage square root and the two bit-per-stage dividers set the depth,
// and every stage advances together.
// Reset: arst_n clears all valid bits and loads the register defaults; no clearing pass.
// Depends on tek_pkg, tek_sat_add, tek_sqrt_pipe and tek_div_pipe.
module track_extrapolate_with_magnet_kick_core #(
	parameter int POS_WIDTH = tek_pkg::POS_WIDTH_DEF,
	parameter int MOM_WIDTH = tek_pkg::MOM_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Input words.
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: start_x, start_y, start_z, mom_x, mom_y, mom_z, target_z,
	// then zero padding to a whole byte.
	input  logic [((4*POS_WIDTH+3*MOM_WIDTH+7)/8)*8-1:0] s_tdata,
	// Result words.
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0 up: x_at_target, y_at_target, then zero padding.
	output logic [((2*POS_WIDTH+7)/8)*8-1:0] m_tdata,
	// Fields from bit 0 up: kick_taken, status.
	output logic [3:0] m_tuser,
	// Register writes: index 0 is magnet_plane_z, index 1 is kick_momentum.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tek_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((POS_WIDTH > tek_pkg::KICK_WIDTH) ? POS_WIDTH : tek_pkg::KICK_WIDTH)-1:0]
		cfg_data
);

	localparam int P = POS_WIDTH;
	localparam int M = MOM_WIDTH;
	localparam int K = tek_pkg::KICK_WIDTH;
	// Magnitude width of any momentum, the kicked px included.
	localparam int PNW = ((M - 1 > K) ? M - 1 : K) + 1;
	localparam int PNX = PNW + 1;
	// Width of |p| * |dz| and so of each slope quotient.
	localparam int NW = PNW + P;
	// Width of the squared momenta and of the square root radicand.
	localparam int SQW = 2 * PNW;
	localparam int OUT_W = ((2 * P + 7) / 8) * 8;
	localparam logic [M-1:0] DIV_ONE = M'(1);

	localparam int SB1_W = 2*NW + 2 + M + 2*P + 5 + (P + 1) + PNX + M;
	localparam int SB2_W = 2 + 2*P + 5 + (P + 1) + PNX + 2*M;
	localparam int SB3_W = 2 + 4*P + 4;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; they are expected
	// only while no word is in flight.
	// ------------------------------------------------------------------
	logic signed [P-1:0] magnet_z_q;
	logic        [K-1:0] kick_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnet_z_q <= P'(tek_pkg::MAGNET_Z_RESET);
			kick_q <= K'(tek_pkg::KICK_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				tek_pkg::CFG_MAGNET_Z: magnet_z_q <= cfg_data[P-1:0];
				tek_pkg::CFG_KICK:     kick_q <= cfg_data[K-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// The whole pipeline moves as one. It advances whenever the output
	// register is empty or its word is being taken, so a stall holds every
	// stage in place and nothing is dropped or repeated.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic adv;

	assign adv = !out_valid_q || m_tready;
	assign s_tready = adv;

	// Stage 1: the accepted word and a snapshot of the registers.
	logic                vld_s1;
	logic signed [P-1:0] x0_s1, y0_s1, z0_s1, z1_s1, mz_s1;
	logic signed [M-1:0] px_s1, py_s1, pz_s1;
	logic        [K-1:0] kick_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1 <= s_tdata[P-1:0];
			y0_s1 <= s_tdata[2*P-1:P];
			z0_s1 <= s_tdata[3*P-1:2*P];
			px_s1 <= s_tdata[3*P+M-1:3*P];
			py_s1 <= s_tdata[3*P+2*M-1:3*P+M];
			pz_s1 <= s_tdata[3*P+3*M-1:3*P+2*M];
			z1_s1 <= s_tdata[4*P+3*M-1:3*P+3*M];
			mz_s1 <= magnet_z_q;
			kick_s1 <= kick_q;
		end
	end

	// Crossing test, first-leg distance, kicked px and the magnitudes that
	// feed the multipliers. A start or target exactly on the plane is no crossing.
	logic signed [P:0]     z0e_c, z1e_c, me_c, dz1_c, dz2_c, ndz1_c;
	logic signed [PNW:0]   pxe_c, ke_c, pxn_c, npxn_c;
	logic        [M-1:0]   npx_c, npy_c;
	logic        [PNW-1:0] apx_c, apy_c, apxn_c;
	logic        [P-1:0]   adz1_c;
	tek_pkg::code_t        kt_c;
	logic                  pzbad_c;

	always_comb begin
		z0e_c = (P+1)'(z0_s1);
		z1e_c = (P+1)'(z1_s1);
		me_c = (P+1)'(mz_s1);
		if (z0e_c < me_c && z1e_c > me_c) begin
			kt_c = tek_pkg::KT_FWD;
		end else if (z0e_c > me_c && z1e_c < me_c) begin
			kt_c = tek_pkg::KT_BWD;
		end else begin
			kt_c = tek_pkg::KT_NONE;
		end
		// With a crossing the first leg ends at the magnet plane.
		dz1_c = (kt_c != tek_pkg::KT_NONE) ? me_c - z0e_c : z1e_c - z0e_c;
		dz2_c = z1e_c - me_c;
		ndz1_c = -dz1_c;
		adz1_c = dz1_c[P] ? ndz1_c[P-1:0] : dz1_c[P-1:0];
		npx_c = -px_s1;
		npy_c = -py_s1;
		apx_c = PNW'(px_s1[M-1] ? npx_c : px_s1);
		apy_c = PNW'(py_s1[M-1] ? npy_c : py_s1);
		pxe_c = (PNW+1)'(px_s1);
		ke_c = $signed(PNX'(kick_s1));
		pxn_c = (kt_c == tek_pkg::KT_FWD) ? pxe_c - ke_c : pxe_c + ke_c;
		npxn_c = -pxn_c;
		apxn_c = pxn_c[PNW] ? npxn_c[PNW-1:0] : pxn_c[PNW-1:0];
		pzbad_c = pz_s1[M-1] || (pz_s1 == '0);
	end

	// Stage 2: first-leg products and the squared momenta.
	logic                  vld_s2;
	logic        [NW-1:0]  prod1x_s2, prod1y_s2;
	logic                  neg1x_s2, neg1y_s2;
	logic        [SQW-1:0] sqa_s2, sqb_s2;
	logic        [M-1:0]   div1_s2;
	logic signed [P-1:0]   x0_s2, y0_s2;
	tek_pkg::code_t        kt_s2;
	logic                  pzbad_s2;
	logic signed [P:0]     dz2_s2;
	logic signed [PNW:0]   pxn_s2;
	logic signed [M-1:0]   py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod1x_s2 <= NW'(apx_c) * NW'(adz1_c);
			prod1y_s2 <= NW'(apy_c) * NW'(adz1_c);
			neg1x_s2 <= px_s1[M-1] ^ dz1_c[P];
			neg1y_s2 <= py_s1[M-1] ^ dz1_c[P];
			sqa_s2 <= SQW'(apx_c) * SQW'(apx_c)
				+ SQW'(pz_s1[M-2:0]) * SQW'(pz_s1[M-2:0]);
			sqb_s2 <= SQW'(apxn_c) * SQW'(apxn_c);
			// A divisor of one keeps the divider tidy when the result is discarded.
			div1_s2 <= pzbad_c ? DIV_ONE : {1'b0, pz_s1[M-2:0]};
			x0_s2 <= x0_s1;
			y0_s2 <= y0_s1;
			kt_s2 <= kt_c;
			pzbad_s2 <= pzbad_c;
			dz2_s2 <= dz2_c;
			pxn_s2 <= pxn_c;
			py_s2 <= py_s1;
		end
	end

	// Stage 3: the kick check and the square root radicand.
	logic           cross_c, kbad_c, use2_c;
	tek_pkg::code_t status_c;

	always_comb begin
		cross_c = (kt_s2 != tek_pkg::KT_NONE);
		kbad_c = cross_c && !pzbad_s2 && (sqb_s2 >= sqa_s2);
		use2_c = cross_c && !pzbad_s2 && !kbad_c;
		if (pzbad_s2) begin
			status_c = tek_pkg::ST_PZ_BAD;
		end else if (kbad_c) begin
			status_c = tek_pkg::ST_KICK_BAD;
		end else begin
			status_c = tek_pkg::ST_OK;
		end
	end

	logic                  vld_s3;
	logic        [SQW-1:0] rad_s3;
	logic        [NW-1:0]  prod1x_s3, prod1y_s3;
	logic                  neg1x_s3, neg1y_s3;
	logic        [M-1:0]   div1_s3;
	logic signed [P-1:0]   x0_s3, y0_s3;
	tek_pkg::code_t        kt_s3, status_s3;
	logic                  use2_s3;
	logic signed [P:0]     dz2_s3;
	logic signed [PNW:0]   pxn_s3;
	logic signed [M-1:0]   py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= use2_c ? sqa_s2 - sqb_s2 : '0;
			prod1x_s3 <= prod1x_s2;
			prod1y_s3 <= prod1y_s2;
			neg1x_s3 <= neg1x_s2;
			neg1y_s3 <= neg1y_s2;
			div1_s3 <= div1_s2;
			x0_s3 <= x0_s2;
			y0_s3 <= y0_s2;
			kt_s3 <= kt_s2;
			status_s3 <= status_c;
			use2_s3 <= use2_c;
			dz2_s3 <= dz2_s2;
			pxn_s3 <= pxn_s2;
			py_s3 <= py_s2;
		end
	end

	// New pz after the kick: floor(sqrt(px^2 + pz^2 - px'^2)).
	logic                  sq_vld;
	logic        [PNW-1:0] sq_root;
	logic        [SB1_W-1:0] sq_side;
	logic        [NW-1:0]  prod1x_sq, prod1y_sq;
	logic                  neg1x_sq, neg1y_sq;
	logic        [M-1:0]   div1_sq;
	logic signed [P-1:0]   x0_sq, y0_sq;
	tek_pkg::code_t        kt_sq, status_sq;
	logic                  use2_sq;
	logic signed [P:0]     dz2_sq;
	logic signed [PNW:0]   pxn_sq;
	logic signed [M-1:0]   py_sq;

	tek_sqrt_pipe #(
		.RAD_W (SQW),
		.SB_W  (SB1_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.rad       (rad_s3),
		.side_in   ({prod1x_s3, prod1y_s3, neg1x_s3, neg1y_s3, div1_s3, x0_s3, y0_s3,
			kt_s3, status_s3, use2_s3, dz2_s3, pxn_s3, py_s3}),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	assign {prod1x_sq, prod1y_sq, neg1x_sq, neg1y_sq, div1_sq, x0_sq, y0_sq,
		kt_sq, status_sq, use2_sq, dz2_sq, pxn_sq, py_sq} = sq_side;

	// First leg: p * dz / pz for x and y.
	logic                  d1_vld;
	logic        [NW-1:0]  q1x, q1y;
	logic        [SB2_W-1:0] d1_side;
	logic                  neg1x_d1, neg1y_d1;
	logic signed [P-1:0]   x0_d1, y0_d1;
	tek_pkg::code_t        kt_d1, status_d1;
	logic                  use2_d1;
	logic signed [P:0]     dz2_d1;
	logic signed [PNW:0]   pxn_d1;
	logic signed [M-1:0]   py_d1;
	logic        [M-1:0]   pzn_d1;

	tek_div_pipe #(
		.NUM_W (NW),
		.DEN_W (M),
		.SB_W  (SB2_W)
	) u_div_leg1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_vld),
		.num_a     (prod1x_sq),
		.num_b     (prod1y_sq),
		.den       (div1_sq),
		.side_in   ({neg1x_sq, neg1y_sq, x0_sq, y0_sq, kt_sq, status_sq, use2_sq,
			dz2_sq, pxn_sq, py_sq, sq_root[M-1:0]}),
		.out_valid (d1_vld),
		.quo_a     (q1x),
		.quo_b     (q1y),
		.side_out  (d1_side)
	);

	assign {neg1x_d1, neg1y_d1, x0_d1, y0_d1, kt_d1, status_d1, use2_d1,
		dz2_d1, pxn_d1, py_d1, pzn_d1} = d1_side;

	// Position after the first leg. Without a crossing this is already the
	// answer, and the second leg adds zero.
	logic signed [P-1:0] xm_c, ym_c;

	tek_sat_add #(.POS_W(P), .Q_W(NW)) u_sat_xm (
		.base (x0_d1), .quo (q1x), .neg (neg1x_d1), .sum (xm_c)
	);

	tek_sat_add #(.POS_W(P), .Q_W(NW)) u_sat_ym (
		.base (y0_d1), .quo (q1y), .neg (neg1y_d1), .sum (ym_c)
	);

	logic signed [PNW:0]   npxn2_c;
	logic        [M-1:0]   npy2_c;
	logic signed [P:0]     ndz2_c;
	logic        [PNW-1:0] ap2x_c, ap2y_c;
	logic        [P-1:0]   adz2_c;

	always_comb begin
		npxn2_c = -pxn_d1;
		npy2_c = -py_d1;
		ndz2_c = -dz2_d1;
		ap2x_c = use2_d1 ? (pxn_d1[PNW] ? npxn2_c[PNW-1:0] : pxn_d1[PNW-1:0]) : '0;
		ap2y_c = use2_d1 ? PNW'(py_d1[M-1] ? npy2_c : py_d1) : '0;
		adz2_c = dz2_d1[P] ? ndz2_c[P-1:0] : dz2_d1[P-1:0];
	end

	// Stage 4: magnet-plane position and second-leg operands.
	logic                  vld_s4;
	logic signed [P-1:0]   xm_s4, ym_s4, x0_s4, y0_s4;
	logic        [PNW-1:0] ap2x_s4, ap2y_s4;
	logic        [P-1:0]   adz2_s4;
	logic                  neg2x_s4, neg2y_s4;
	logic        [M-1:0]   d2_s4;
	tek_pkg::code_t        kt_s4, status_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xm_s4 <= xm_c;
			ym_s4 <= ym_c;
			x0_s4 <= x0_d1;
			y0_s4 <= y0_d1;
			ap2x_s4 <= ap2x_c;
			ap2y_s4 <= ap2y_c;
			adz2_s4 <= adz2_c;
			neg2x_s4 <= pxn_d1[PNW] ^ dz2_d1[P];
			neg2y_s4 <= py_d1[M-1] ^ dz2_d1[P];
			d2_s4 <= use2_d1 ? pzn_d1 : DIV_ONE;
			kt_s4 <= kt_d1;
			status_s4 <= status_d1;
		end
	end

	// Stage 5: second-leg products.
	logic                 vld_s5;
	logic        [NW-1:0] prod2x_s5, prod2y_s5;
	logic signed [P-1:0]  xm_s5, ym_s5, x0_s5, y0_s5;
	logic                 neg2x_s5, neg2y_s5;
	logic        [M-1:0]  d2_s5;
	tek_pkg::code_t       kt_s5, status_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod2x_s5 <= NW'(ap2x_s4) * NW'(adz2_s4);
			prod2y_s5 <= NW'(ap2y_s4) * NW'(adz2_s4);
			xm_s5 <= xm_s4;
			ym_s5 <= ym_s4;
			x0_s5 <= x0_s4;
			y0_s5 <= y0_s4;
			neg2x_s5 <= neg2x_s4;
			neg2y_s5 <= neg2y_s4;
			d2_s5 <= d2_s4;
			kt_s5 <= kt_s4;
			status_s5 <= status_s4;
		end
	end

	// Second leg: from the magnet plane to the target with the kicked momentum.
	logic                 d2_vld;
	logic        [NW-1:0] q2x, q2y;
	logic        [SB3_W-1:0] d2_side;
	logic                 neg2x_d2, neg2y_d2;
	logic signed [P-1:0]  xm_d2, ym_d2, x0_d2, y0_d2;
	tek_pkg::code_t       kt_d2, status_d2;

	tek_div_pipe #(
		.NUM_W (NW),
		.DEN_W (M),
		.SB_W  (SB3_W)
	) u_div_leg2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.num_a     (prod2x_s5),
		.num_b     (prod2y_s5),
		.den       (d2_s5),
		.side_in   ({neg2x_s5, neg2y_s5, xm_s5, ym_s5, x0_s5, y0_s5, kt_s5, status_s5}),
		.out_valid (d2_vld),
		.quo_a     (q2x),
		.quo_b     (q2y),
		.side_out  (d2_side)
	);

	assign {neg2x_d2, neg2y_d2, xm_d2, ym_d2, x0_d2, y0_d2, kt_d2, status_d2} = d2_side;

	logic signed [P-1:0] ox_c, oy_c;

	tek_sat_add #(.POS_W(P), .Q_W(NW)) u_sat_ox (
		.base (xm_d2), .quo (q2x), .neg (neg2x_d2), .sum (ox_c)
	);

	tek_sat_add #(.POS_W(P), .Q_W(NW)) u_sat_oy (
		.base (ym_d2), .quo (q2y), .neg (neg2y_d2), .sum (oy_c)
	);

	// Output register. A flagged track reports its start point unchanged.
	logic signed [P-1:0] out_x_q, out_y_q;
	tek_pkg::code_t      out_kt_q, out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= (status_d2 == tek_pkg::ST_OK) ? ox_c : x0_d2;
			out_y_q <= (status_d2 == tek_pkg::ST_OK) ? oy_c : y0_d2;
			out_kt_q <= kt_d2;
			out_status_q <= status_d2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_W'({out_y_q, out_x_q});
	assign m_tuser = {out_status_q, out_kt_q};

`ifndef NO_ASSERTIONS
	a_stall_shared: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output register state");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted word did not enter the first stage");

	a_kick_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:2] == tek_pkg::ST_KICK_BAD)
		|-> m_tuser[1:0] != tek_pkg::KT_NONE)
		else $error("kick flagged on a track that does not cross the magnet");
`endif

endmodule
